FILE: rtl/csma_pkg.sv
// Shared types and constants for the CSMA/CA channel access unit.
// Used by the configuration registers, the access core and the top level.
package csma_pkg;

	localparam int unsigned MAX_OVERLAP = 15;
	localparam int unsigned OVL_W = $clog2(MAX_OVERLAP + 1);

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [2:0] REG_MIN_EXP     = 3'd0;
	localparam logic [2:0] REG_MAX_EXP     = 3'd1;
	localparam logic [2:0] REG_MAX_RETRIES = 3'd2;
	localparam logic [2:0] REG_UNIT_PERIOD = 3'd3;
	localparam logic [2:0] REG_INIT_OFFSET = 3'd4;

	localparam logic [3:0]  RST_MIN_EXP     = 4'd3;
	localparam logic [3:0]  RST_MAX_EXP     = 4'd5;
	localparam logic [3:0]  RST_MAX_RETRIES = 4'd4;
	localparam logic [15:0] RST_UNIT_PERIOD = 16'd320;
	localparam logic [19:0] RST_INIT_OFFSET = 20'd30000;

	localparam logic [2:0] KIND_START    = 3'd0;
	localparam logic [2:0] KIND_BACKOFF  = 3'd1;
	localparam logic [2:0] KIND_TX_BEGIN = 3'd2;
	localparam logic [2:0] KIND_TX_END   = 3'd3;
	localparam logic [2:0] KIND_RX_BEGIN = 3'd4;
	localparam logic [2:0] KIND_RX_END   = 3'd5;

	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_BACKOFF  = 3'd1;
	localparam logic [2:0] ACT_TRANSMIT = 3'd2;
	localparam logic [2:0] ACT_FAIL     = 3'd3;
	localparam logic [2:0] ACT_ACCEPT   = 3'd4;
	localparam logic [2:0] ACT_DROP     = 3'd5;

	typedef struct packed {
		logic [3:0]  min_exponent;
		logic [3:0]  max_exponent;
		logic [3:0]  max_retries;
		logic [15:0] unit_period;
		logic [19:0] initial_offset;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        channel_clear;
		logic [14:0] random_bits;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] delay;
		logic [3:0]  retry_count;
		logic [3:0]  exponent;
		logic        tx_busy;
		logic        collision;
	} res_item_t;

endpackage

FILE: rtl/csma_cfg.sv
// APB-style configuration registers of the CSMA/CA unit.
// Depends on csma_pkg for the register map, reset values and cfg_t.
module csma_cfg
	import csma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_exponent   <= RST_MIN_EXP;
			cfg_q.max_exponent   <= RST_MAX_EXP;
			cfg_q.max_retries    <= RST_MAX_RETRIES;
			cfg_q.unit_period    <= RST_UNIT_PERIOD;
			cfg_q.initial_offset <= RST_INIT_OFFSET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MIN_EXP:     cfg_q.min_exponent   <= pwdata[3:0];
				REG_MAX_EXP:     cfg_q.max_exponent   <= pwdata[3:0];
				REG_MAX_RETRIES: cfg_q.max_retries    <= pwdata[3:0];
				REG_UNIT_PERIOD: cfg_q.unit_period    <= pwdata[15:0];
				REG_INIT_OFFSET: cfg_q.initial_offset <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_MIN_EXP:     prdata = DATA_W'(cfg_q.min_exponent);
			REG_MAX_EXP:     prdata = DATA_W'(cfg_q.max_exponent);
			REG_MAX_RETRIES: prdata = DATA_W'(cfg_q.max_retries);
			REG_UNIT_PERIOD: prdata = DATA_W'(cfg_q.unit_period);
			REG_INIT_OFFSET: prdata = DATA_W'(cfg_q.initial_offset);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: rtl/csma_core.sv
// Access state and per-request update logic of the CSMA/CA unit.
// Depends on csma_pkg for cfg_t, the request and result types and the codes.
module csma_core
	import csma_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  req_item_t item,
	input  logic      advance,
	output res_item_t result
);

	logic [3:0]       retries_q;
	logic [3:0]       exp_q;
	logic [OVL_W-1:0] overlap_q;
	logic             collided_q;
	logic             tx_q;

	logic [3:0]       retries_d;
	logic [3:0]       exp_d;
	logic [OVL_W-1:0] overlap_d;
	logic             collided_d;
	logic             tx_d;
	logic [2:0]       action;
	logic             use_offset;
	logic             use_draw;
	logic [4:0]       exp_inc;
	logic [15:0]      mask;
	logic [14:0]      drawn;
	logic [30:0]      product;
	logic [31:0]      delay;

	always_comb begin
		retries_d  = retries_q;
		exp_d      = exp_q;
		overlap_d  = overlap_q;
		collided_d = collided_q;
		tx_d       = tx_q;
		action     = ACT_NONE;
		use_offset = 1'b0;
		use_draw   = 1'b0;
		exp_inc    = 5'(exp_q) + 5'd1;
		case (item.kind)
			KIND_START: begin
				retries_d  = '0;
				exp_d      = cfg.min_exponent;
				use_offset = 1'b1;
				use_draw   = 1'b1;
				action     = ACT_BACKOFF;
			end
			KIND_BACKOFF: begin
				if (item.channel_clear) begin
					action = ACT_TRANSMIT;
				end else begin
					if (retries_q != 4'd15) begin
						retries_d = retries_q + 4'd1;
					end
					if (exp_inc > 5'(cfg.max_exponent)) begin
						exp_d = cfg.max_exponent;
					end else begin
						exp_d = exp_inc[3:0];
					end
					if (retries_d > cfg.max_retries) begin
						action = ACT_FAIL;
					end else begin
						use_draw = 1'b1;
						action   = ACT_BACKOFF;
					end
				end
			end
			KIND_TX_BEGIN: tx_d = 1'b1;
			KIND_TX_END:   tx_d = 1'b0;
			KIND_RX_BEGIN: begin
				if (overlap_q < OVL_W'(MAX_OVERLAP)) begin
					overlap_d = overlap_q + OVL_W'(1);
				end
				if (overlap_d > OVL_W'(1)) begin
					collided_d = 1'b1;
				end
			end
			KIND_RX_END: begin
				if (overlap_q != '0) begin
					overlap_d = overlap_q - OVL_W'(1);
				end
				action = collided_q ? ACT_DROP : ACT_ACCEPT;
				if (overlap_d == '0) begin
					collided_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign mask    = (16'd1 << exp_d) - 16'd1;
	assign drawn   = item.random_bits & mask[14:0];
	assign product = 31'(cfg.unit_period) * 31'(drawn);

	always_comb begin
		delay = '0;
		if (use_draw) begin
			delay = 32'(product) + (use_offset ? 32'(cfg.initial_offset) : 32'd0);
		end
	end

	assign result.action      = action;
	assign result.delay       = delay;
	assign result.retry_count = retries_d;
	assign result.exponent    = exp_d;
	assign result.tx_busy     = tx_d;
	assign result.collision   = collided_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retries_q  <= '0;
			exp_q      <= RST_MIN_EXP;
			overlap_q  <= '0;
			collided_q <= 1'b0;
			tx_q       <= 1'b0;
		end else if (advance) begin
			retries_q  <= retries_d;
			exp_q      <= exp_d;
			overlap_q  <= overlap_d;
			collided_q <= collided_d;
			tx_q       <= tx_d;
		end
	end

endmodule

FILE: rtl/csma_ca_channel_access.sv
// Unslotted CSMA/CA channel access unit, top level.
// An accepted request is registered in item_s1; its result is then registered in res_q.
// Throughput: one request per cycle while res_stall is low, set by the state update in csma_core.
// An input register and a result register hold one request each, so a request
// is taken while a finished result waits. Reset resets the core state, clears the
// valid flags and loads the register defaults; item_s1 and res_q are not reset.
module csma_ca_channel_access
	import csma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_item_t         req_data,
	output logic              res_valid,
	input  logic              res_stall,
	output res_item_t         res_data
);

	cfg_t      cfg;
	req_item_t item_s1;
	logic      valid_s1;
	res_item_t result;
	res_item_t res_q;
	logic      res_valid_q;
	logic      advance;
	logic      req_take;

	csma_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	csma_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (result)
	);

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1 <= req_data;
		end
		if (advance) begin
			res_q <= result;
		end
	end

endmodule
